// File: sv/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg: shared types and constants for the ARP resolver cache
// Holds the table geometry, item and result records and the field codes.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int TABLE_DEPTH = 8;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] OP_PAYLOAD = 2'd0;
  localparam logic [1:0] OP_LOOKUP  = 2'd1;
  localparam logic [1:0] OP_RESOLVE = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_REP  = 2'd2;

  localparam logic [15:0] ARP_OP_REQ  = 16'h0001;
  localparam logic [15:0] ARP_REPLY   = 16'h0002;
  localparam logic [15:0] HW_ETHER    = 16'h0001;
  localparam logic [15:0] PROTO_IPV4  = 16'h0800;
  localparam logic [15:0] ADDR_LENS   = 16'h0604;
  localparam logic [47:0] MAC_BCAST   = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REG_OWN_IP   = 2'd0;
  localparam logic [1:0] REG_OWN_MAC  = 2'd1;
  localparam logic [1:0] REG_INTERVAL = 2'd2;
  localparam logic [1:0] REG_MAX_ATT  = 2'd3;

  localparam logic [15:0] INTERVAL_RST = 16'd250;
  localparam logic [6:0]  MAX_ATT_RST  = 7'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic        frame_short;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [15:0] addr_lengths;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
    logic [31:0] query_ip;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [47:0] frame_dest_mac;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
    logic        request_status;
    logic        timer_active;
    logic        last;
  } result_t;

  // one table entry as stored
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic        resolved;
    logic [6:0]  attempts;
    logic [31:0] start;
  } entry_t;

  typedef struct packed {
    logic [31:0] own_ip;
    logic [47:0] own_mac;
    logic [15:0] interval;
    logic [6:0]  max_att;
  } cfg_t;

endpackage

// File: sv/arc_if.sv
// ----------------------------------------------------------------------------
// arc_if: valid/ready channel interfaces
// Item, result and register write channels.
// ----------------------------------------------------------------------------
interface arc_item_if;
  import arc_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arc_result_if;
  import arc_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [47:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: sv/arp_resolver_cache_top.sv
// ----------------------------------------------------------------------------
// arp_resolver_cache_top: ARP resolver with IP-to-MAC cache
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_ready  ARP fields, operation, query_ip, now_ms
//   out_     out  out_valid/out_ready frame, lookup and status fields, last
//   cfg_     in   cfg_valid/cfg_ready index (2b), wdata (48b)
//
// One request at a time; each entry is read from the store's registered port,
// then scanned. An output stall holds the sequencer where a result waits to
// load, and in the reply step even when no reply is sent.
// Reset is synchronous; no clearing pass, the store's valid bits reset at once.
// ----------------------------------------------------------------------------
module arp_resolver_cache_top (
  input  logic        clk,
  input  logic        rst_n,
  arc_item_if.sink    in_ch,
  arc_result_if.source out_ch,
  arc_cfg_if.sink     cfg_ch
);
  import arc_pkg::*;

  cfg_t             cfg;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data;
  logic             wr_en;

  arc_cfg_regs u_regs (.clk, .rst_n, .cfg_ch, .cfg);

  arc_table_mem u_mem (
    .clk, .rst_n, .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );

  arc_engine u_eng (
    .clk, .rst_n, .in_ch, .out_ch, .cfg,
    .rd_addr, .rd_data, .wr_en, .wr_addr, .wr_data
  );
endmodule

// File: sv/arc_table_mem.sv
// ----------------------------------------------------------------------------
// arc_table_mem: entry store
// One read port with registered data, one write port. Valid bits mark
// written entries; an invalid entry reads as all zero.
// ----------------------------------------------------------------------------
module arc_table_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [arc_pkg::IDX_W-1:0] rd_addr,
  output arc_pkg::entry_t      rd_data,
  input  logic                 wr_en,
  input  logic [arc_pkg::IDX_W-1:0] wr_addr,
  input  arc_pkg::entry_t      wr_data
);
  import arc_pkg::*;

  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  entry_t                 rd_r;
  logic                   rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) vld_r[wr_addr] <= 1'b1;
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_r : '0;
endmodule

// File: sv/arc_engine.sv
// ----------------------------------------------------------------------------
// arc_engine: per-item sequencer
// Scans the entry store one entry at a time (a read state, then a scan state),
// updates entries and emits results through a one-deep output register.
// ----------------------------------------------------------------------------
module arc_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  arc_item_if.sink                  in_ch,
  arc_result_if.source              out_ch,
  input  arc_pkg::cfg_t             cfg,
  output logic [arc_pkg::IDX_W-1:0] rd_addr,
  input  arc_pkg::entry_t           rd_data,
  output logic                      wr_en,
  output logic [arc_pkg::IDX_W-1:0] wr_addr,
  output arc_pkg::entry_t           wr_data
);
  import arc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_EMIT  = 6'b010000,
    S_CLOSE = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  item_t              item_r;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;     // stop-search / match flag
  logic [IDX_W-1:0]   slot_r, slot_nxt;
  logic               free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic               hit_r, hit_nxt;
  logic [47:0]        hmac_r, hmac_nxt;
  logic               status_r, status_nxt;
  logic               pend_r, pend_nxt;
  logic               timer_r, timer_nxt;
  result_t            out_r, out_nxt;
  logic               ov_r, ov_nxt;

  logic        in_use, ip_eq, pkt_ok, out_free, expired;
  logic [31:0] elapsed;
  logic [IDX_W-1:0] cur;

  assign cur      = idx_r[IDX_W-1:0];
  assign in_use   = rd_data.resolved || (rd_data.attempts != 7'd0);
  assign out_free = !ov_r || out_ch.ready;
  assign pkt_ok   = !item_r.frame_short && item_r.hw_type == HW_ETHER &&
                    item_r.proto_type == PROTO_IPV4 && item_r.addr_lengths == ADDR_LENS;
  assign elapsed  = item_r.now_ms - rd_data.start;
  assign expired  = elapsed >= {16'd0, cfg.interval};
  assign ip_eq    = (item_r.operation == OP_PAYLOAD) ? rd_data.ip == item_r.sender_ip
                                                     : rd_data.ip == item_r.query_ip;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = out_r;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    found_nxt   = found_r;
    slot_nxt    = slot_r;
    free_ok_nxt = free_ok_r;
    free_nxt    = free_r;
    hit_nxt     = hit_r;
    hmac_nxt    = hmac_r;
    status_nxt  = status_r;
    pend_nxt    = pend_r;
    timer_nxt   = timer_r;
    out_nxt     = out_r;
    ov_nxt      = ov_r && !out_ch.ready;
    rd_addr     = cur;
    wr_en       = 1'b0;
    wr_addr     = cur;
    wr_data     = rd_data;

    case (state_r)
      S_IDLE: begin
        idx_nxt = '0; found_nxt = 1'b0; free_ok_nxt = 1'b0; hit_nxt = 1'b0;
        hmac_nxt = '0; status_nxt = 1'b0; pend_nxt = 1'b0;
        if (in_ch.valid) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // optional reply frame before the scan
        if (out_free) begin
          if (item_r.operation == OP_PAYLOAD && pkt_ok && item_r.arp_op == ARP_OP_REQ &&
              item_r.target_ip == cfg.own_ip) begin
            out_nxt = '0;
            out_nxt.send_kind        = KIND_REP;
            out_nxt.frame_dest_mac   = item_r.sender_mac;
            out_nxt.frame_target_mac = item_r.sender_mac;
            out_nxt.frame_target_ip  = item_r.sender_ip;
            out_nxt.timer_active     = timer_r;
            ov_nxt = 1'b1;
          end
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_SCAN;
      S_SCAN: begin
        state_nxt = S_READ;
        case (item_r.operation)
          OP_PAYLOAD: begin
            if (pkt_ok && item_r.arp_op == ARP_REPLY && item_r.target_mac == cfg.own_mac &&
                item_r.target_ip == cfg.own_ip && !found_r && in_use && ip_eq) begin
              found_nxt = 1'b1;
              wr_en = 1'b1;
              wr_data.mac = item_r.sender_mac;
              wr_data.resolved = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (!found_r && in_use && ip_eq) begin
              found_nxt = 1'b1;
              hit_nxt   = rd_data.resolved;
              hmac_nxt  = rd_data.resolved ? rd_data.mac : '0;
            end
          end
          OP_RESOLVE: begin
            if (!found_r && in_use && ip_eq) begin
              if (!rd_data.resolved) begin
                found_nxt = 1'b1;
                slot_nxt  = '0;
                pend_nxt  = 1'b1;     // already pending: stop, nothing sent
              end else begin
                slot_nxt = cur;
                hit_nxt  = 1'b1;      // resolved match seen (last one wins)
              end
            end
            if (!in_use && !free_ok_r) begin
              free_ok_nxt = 1'b1;
              free_nxt    = cur;
            end
          end
          default: begin
            if (timer_r && in_use && !rd_data.resolved) begin
              pend_nxt = 1'b1;
              if (expired) begin
                if (rd_data.attempts >= cfg.max_att) begin
                  wr_en = 1'b1;
                  wr_data = '0;
                end else if (out_free) begin
                  wr_en = 1'b1;
                  wr_data.attempts = rd_data.attempts + 7'd1;
                  wr_data.start    = item_r.now_ms;
                  out_nxt = '0;
                  out_nxt.send_kind       = KIND_REQ;
                  out_nxt.frame_dest_mac  = MAC_BCAST;
                  out_nxt.frame_target_ip = rd_data.ip;
                  out_nxt.timer_active    = timer_r;
                  ov_nxt = 1'b1;
                end else begin
                  state_nxt = S_SCAN;  // hold until output register frees
                end
              end
            end
          end
        endcase
        if (state_nxt == S_READ) begin
          if (idx_r == CNT_W'(TABLE_DEPTH - 1)) begin
            state_nxt = S_ALLOC;
            if (item_r.operation == OP_TICK && timer_r && !pend_nxt) timer_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
            rd_addr = idx_nxt[IDX_W-1:0];
          end
        end else begin
          rd_addr = cur;
        end
      end
      S_ALLOC: begin
        if (item_r.operation == OP_RESOLVE && !pend_r) begin
          if (!hit_r && !free_ok_r) begin
            status_nxt = 1'b1;
            state_nxt  = S_CLOSE;
          end else if (out_free) begin
            wr_en   = 1'b1;
            wr_addr = hit_r ? slot_r : free_r;
            wr_data = '0;
            wr_data.ip       = item_r.query_ip;
            wr_data.attempts = 7'd1;
            wr_data.start    = item_r.now_ms;
            wr_data.resolved = hit_r;
            wr_data.mac      = hmac_r;
            timer_nxt = 1'b1;
            out_nxt = '0;
            out_nxt.send_kind       = KIND_REQ;
            out_nxt.frame_dest_mac  = MAC_BCAST;
            out_nxt.frame_target_ip = item_r.query_ip;
            out_nxt.timer_active    = 1'b1;
            ov_nxt = 1'b1;
            hit_nxt = 1'b0;
            state_nxt = S_CLOSE;
          end
        end else begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_nxt = '0;
          out_nxt.last           = 1'b1;
          out_nxt.timer_active   = timer_r;
          out_nxt.request_status = status_r;
          if (item_r.operation == OP_LOOKUP) begin
            out_nxt.lookup_hit = hit_r;
            out_nxt.lookup_mac = hmac_r;
          end
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // resolve of a resolved entry keeps its MAC: capture it for write-back
  logic [47:0] keep_mac;
  assign keep_mac = (state_r == S_SCAN && item_r.operation == OP_RESOLVE && !found_r &&
                     in_use && ip_eq && rd_data.resolved) ? rd_data.mac : hmac_nxt;

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) item_r <= in_ch.data;
    out_r    <= out_nxt;
    idx_r    <= idx_nxt;
    slot_r   <= slot_nxt;
    free_r   <= free_nxt;
    hmac_r   <= keep_mac;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ov_r      <= 1'b0;
      timer_r   <= 1'b0;
      found_r   <= 1'b0;
      free_ok_r <= 1'b0;
      hit_r     <= 1'b0;
      status_r  <= 1'b0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ov_r      <= ov_nxt;
      timer_r   <= timer_nxt;
      found_r   <= found_nxt;
      free_ok_r <= free_ok_nxt;
      hit_r     <= hit_nxt;
      status_r  <= status_nxt;
      pend_r    <= pend_nxt;
    end
  end
endmodule

// File: sv/arc_cfg_regs.sv
// ----------------------------------------------------------------------------
// arc_cfg_regs: station registers
// Own addresses, retry interval and attempt limit.
// ----------------------------------------------------------------------------
module arc_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  arc_cfg_if.sink       cfg_ch,
  output arc_pkg::cfg_t cfg
);
  import arc_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_ip   <= '0;
      cfg_r.own_mac  <= '0;
      cfg_r.interval <= INTERVAL_RST;
      cfg_r.max_att  <= MAX_ATT_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_OWN_IP:   cfg_r.own_ip   <= cfg_ch.wdata[31:0];
        REG_OWN_MAC:  cfg_r.own_mac  <= cfg_ch.wdata;
        REG_INTERVAL: cfg_r.interval <= cfg_ch.wdata[15:0];
        REG_MAX_ATT:  cfg_r.max_att  <= cfg_ch.wdata[6:0];
        default: ;
      endcase
    end
  end
endmodule

// File: sv/arc_checker.sv
// ----------------------------------------------------------------------------
// arc_checker: port-level checks on the resolver
// ----------------------------------------------------------------------------
module arc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_kind,
  input logic out_last,
  input logic out_hit,
  input logic out_status
);
  import arc_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_NONE |-> !out_last) else $error("frame marked last");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_NONE) else $error("bad closing result");
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !out_hit && !out_status) else $error("flags on frame");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
endmodule

bind arp_resolver_cache_top arc_checker u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.data.send_kind), .out_last(out_ch.data.last),
  .out_hit(out_ch.data.lookup_hit), .out_status(out_ch.data.request_status)
);
